### sv/bero_pkg.sv
package bero_pkg;

    // image geometry
    localparam int MAX_WORDS = 64;
    localparam int ADDR_W    = $clog2(MAX_WORDS);
    localparam int WORD_W    = 64;
    localparam int ROW_W     = 12;
    localparam int COL_W     = 6;
    localparam int WPR_W     = 7;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WORDS_PER_ROW = 2'd0,
        CFG_ROW_TOTAL     = 2'd1,
        CFG_BORDER_FILL   = 2'd2
    } cfg_index_t;

    localparam logic [WPR_W-1:0] WPR_RESET  = 7'd10;
    localparam logic [ROW_W-1:0] ROWS_RESET = 12'd480;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
    localparam logic [FIFO_CNT_W-1:0] ROOM_IDLE = FIFO_CNT_W'(FIFO_DEPTH - 2);
    localparam logic [FIFO_CNT_W-1:0] ROOM_BUSY = FIFO_CNT_W'(FIFO_DEPTH - 4);

    typedef struct packed {
        logic [WPR_W-1:0] words_per_row;
        logic [ROW_W-1:0] row_total;
        logic             border_fill;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] eroded_word;
        logic [ROW_W-1:0]  out_row;
        logic [COL_W-1:0]  out_col;
        logic              frame_end;
    } result_t;

    // up to two results per item; v1 implies v0
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    // horizontal AND with carry across neighbouring words
    function automatic logic [WORD_W-1:0] erode_word(
        input logic [WORD_W-1:0] left,
        input logic [WORD_W-1:0] center,
        input logic [WORD_W-1:0] right
    );
        logic [WORD_W-1:0] from_left;
        logic [WORD_W-1:0] from_right;
        from_left  = {center[WORD_W-2:0], left[WORD_W-1]};
        from_right = {right[0], center[WORD_W-1:1]};
        return center & from_left & from_right;
    endfunction

endpackage

### sv/bero_pix_if.sv
interface bero_pix_if;
    import bero_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [WORD_W-1:0] pixel_word;

    modport source (output valid, output cmd, output pixel_word, input ready);
    modport sink (input valid, input cmd, input pixel_word, output ready);
endinterface

### sv/bero_res_if.sv
interface bero_res_if;
    import bero_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] eroded_word;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
    logic              frame_end;

    modport source (
        output valid, output eroded_word, output out_row, output out_col,
        output frame_end, input ready
    );
    modport sink (
        input valid, input eroded_word, input out_row, input out_col,
        input frame_end, output ready
    );
endinterface

### sv/bero_ram.sv
module bero_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/bero_core.sv
module bero_core
    import bero_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              accept,
    input  logic              cmd,
    input  logic [WORD_W-1:0] pixel_word,
    output logic              busy,
    output push_t             push
);

    // position of the incoming word
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // item in the read-modify-write stage
    logic              s1_valid_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic              s1_flush_reg;
    logic              s1_last_reg;
    logic [WORD_W-1:0] s1_bottom_reg;

    // vertical ANDs of the two previous columns
    logic [WORD_W-1:0] prev_reg, prevprev_reg;

    // forwarding of a write that overlapped the read
    logic                fwd_reg, fwd_next;
    logic [2*WORD_W-1:0] fwd_data_reg;

    logic [WORD_W-1:0]   fill;
    logic [COL_W-1:0]    last_c;
    logic [ROW_W-1:0]    rows;
    logic [COL_W-1:0]    c_eff;
    logic [ROW_W-1:0]    ri_eff;
    logic                flush;
    logic [WORD_W-1:0]   bottom;

    logic [2*WORD_W-1:0] rd_data;
    logic [2*WORD_W-1:0] line_eff;
    logic [2*WORD_W-1:0] wr_data;
    logic [WORD_W-1:0]   upper_eff, middle_eff, up, vert;
    logic                active, has_a, has_b;
    result_t             res_a, res_b;

    assign fill = {WORD_W{cfg.border_fill}};

    // clamp position against the configured geometry
    always_comb
    begin
        if (cfg.words_per_row == '0)
        begin
            last_c = '0;
        end
        else if (cfg.words_per_row > WPR_W'(MAX_WORDS))
        begin
            last_c = COL_W'(MAX_WORDS - 1);
        end
        else
        begin
            last_c = COL_W'(cfg.words_per_row - 7'd1);
        end
        rows   = (cfg.row_total == '0) ? 12'd1 : cfg.row_total;
        c_eff  = (col_reg > last_c) ? last_c : col_reg;
        flush  = (row_reg >= rows);
        ri_eff = flush ? rows : row_reg;
        bottom = (cmd || flush) ? fill : pixel_word;
        if (c_eff == last_c)
        begin
            col_next = '0;
            row_next = flush ? '0 : ri_eff + 12'd1;
        end
        else
        begin
            col_next = c_eff + 6'd1;
            row_next = ri_eff;
        end
    end

    // position and stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            fwd_reg      <= fwd_next;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg    <= c_eff;
            s1_row_reg    <= ri_eff;
            s1_flush_reg  <= flush;
            s1_last_reg   <= (c_eff == last_c);
            s1_bottom_reg <= bottom;
        end
        fwd_data_reg <= wr_data;
    end

    // line buffers: {upper, middle} per word column
    bero_ram #(
        .WIDTH (2*WORD_W),
        .DEPTH (MAX_WORDS)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg[ADDR_W-1:0]),
        .wdata (wr_data),
        .re    (accept),
        .raddr (c_eff[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    assign fwd_next = accept && s1_valid_reg && (c_eff == s1_col_reg);

    // vertical AND, line shift and horizontal erosion
    always_comb
    begin
        line_eff   = fwd_reg ? fwd_data_reg : rd_data;
        upper_eff  = line_eff[2*WORD_W-1:WORD_W];
        middle_eff = line_eff[WORD_W-1:0];
        wr_data    = {middle_eff, s1_bottom_reg};
        active     = (s1_row_reg != '0);
        up         = (s1_row_reg >= 12'd2) ? upper_eff : fill;
        vert       = up & middle_eff & s1_bottom_reg;
        has_a      = active && (s1_col_reg != '0);
        has_b      = active && s1_last_reg;

        res_a.eroded_word = erode_word((s1_col_reg == 6'd1) ? fill : prevprev_reg,
                                       prev_reg, vert);
        res_a.out_row     = s1_row_reg - 12'd1;
        res_a.out_col     = s1_col_reg - 6'd1;
        res_a.frame_end   = 1'b0;

        res_b.eroded_word = erode_word((s1_col_reg == '0) ? fill : prev_reg,
                                       vert, fill);
        res_b.out_row     = s1_row_reg - 12'd1;
        res_b.out_col     = s1_col_reg;
        res_b.frame_end   = s1_flush_reg;

        push.v0 = s1_valid_reg && (has_a || has_b);
        push.v1 = s1_valid_reg && has_a && has_b;
        push.r0 = has_a ? res_a : res_b;
        push.r1 = res_b;
    end

    // column history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= '0;
            prevprev_reg <= '0;
        end
        else if (s1_valid_reg && active)
        begin
            prevprev_reg <= prev_reg;
            prev_reg     <= vert;
        end
    end

    assign busy = s1_valid_reg;

endmodule

### sv/bero_fifo.sv
module bero_fifo
    import bero_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  push_t                 push,
    output logic [FIFO_CNT_W-1:0] level,
    bero_res_if.source            results
);

    result_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_plus1;
    logic [1:0]            n_push;
    logic                  pop;
    result_t               head;

    // pointer and count update
    always_comb
    begin
        n_push       = {1'b0, push.v0} + {1'b0, push.v1};
        pop          = results.valid && results.ready;
        wr_ptr_plus1 = wr_ptr_reg + 1'b1;
        wr_ptr_next  = wr_ptr_reg + FIFO_PTR_W'(n_push);
        rd_ptr_next  = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next   = count_reg + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, two write slots per cycle
    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem_reg[wr_ptr_plus1] <= push.r1;
        end
    end

    // head of queue
    assign head                = mem_reg[rd_ptr_reg];
    assign results.valid       = (count_reg != '0);
    assign results.eroded_word = head.eroded_word;
    assign results.out_row     = head.out_row;
    assign results.out_col     = head.out_col;
    assign results.frame_end   = head.frame_end;
    assign level               = count_reg;

endmodule

### sv/binary_erosion_3x3_packed_top.sv
// 3x3 binary erosion of a bit-packed image stream, 64 pixels per word.
// pixels: valid/ready input channel; cmd 0 carries an image word, cmd 1 a
// flush tick. Words arrive row by row; after the last row the host sends
// one full row of flush ticks, which stands for the border row below.
// results: valid/ready output channel with the eroded word, its row, its
// word column and a frame_end flag on the last word of the frame.
// cfg_we/cfg_index/cfg_data write words_per_row, row_total and border_fill;
// write only while no item is in flight.
// Throughput: one item per cycle while the result queue has room. Each item
// reads the line buffer RAM once and writes it back in the next cycle; a
// same-column overlap is forwarded, so rows of a single word run at full rate.
// The item at column c releases word c-1 of the row above (and at the last
// column also word c); those results pass the stage registers and then the
// result queue before they are presented.
// A receiver stall is absorbed by an 8-entry result queue; pixels.ready drops
// when fewer than four entries are free with an item in flight, or fewer
// than two with none in flight.
// Reset: position returns to row 0, column 0, registers take 10 words,
// 480 rows and fill 0. Line buffer contents are not cleared and need no
// clearing pass: the first two rows of a frame rewrite them before use.
module binary_erosion_3x3_packed_top
    import bero_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bero_pix_if.sink              pixels,
    bero_res_if.source            results
);

    cfg_t                  cfg_reg, cfg_next;
    logic                  accept;
    logic                  busy;
    logic                  room;
    push_t                 push;
    logic [FIFO_CNT_W-1:0] level;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WORDS_PER_ROW: cfg_next.words_per_row = cfg_data[WPR_W-1:0];
                CFG_ROW_TOTAL:     cfg_next.row_total     = cfg_data[ROW_W-1:0];
                CFG_BORDER_FILL:   cfg_next.border_fill   = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.words_per_row <= WPR_RESET;
            cfg_reg.row_total     <= ROWS_RESET;
            cfg_reg.border_fill   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input handshake: room for this item and the one in flight
    assign room          = busy ? (level <= ROOM_BUSY) : (level <= ROOM_IDLE);
    assign pixels.ready  = room;
    assign accept        = pixels.valid && room;

    bero_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .accept     (accept),
        .cmd        (pixels.cmd),
        .pixel_word (pixels.pixel_word),
        .busy       (busy),
        .push       (push)
    );

    bero_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .level   (level),
        .results (results)
    );

endmodule

### sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bero_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 8;
    localparam int TARGET_ITEMS = 1700;
    localparam int SETTLE       = 6;
    localparam int TAIL_CYCLES  = 12;
    localparam int LONG_HOLD    = 300;
    localparam int STUCK_LIMIT  = 3000;

    localparam logic CMD_IMAGE = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [WORD_W-1:0] word;
    } pix_item_t;

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_SPARSE} ready_style_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bero_pix_if pix ();
    bero_res_if res ();

    binary_erosion_3x3_packed_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix),
        .results   (res)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // predictor state: registers, two line stores, column ANDs, position
    logic [WPR_W-1:0]  cfg_wpr  = WPR_RESET;
    logic [ROW_W-1:0]  cfg_rows = ROWS_RESET;
    logic              cfg_fill = 1'b0;
    logic [WORD_W-1:0] two_up [MAX_WORDS];
    logic [WORD_W-1:0] one_up [MAX_WORDS];
    logic [WORD_W-1:0] vcol_prev  = '0;
    logic [WORD_W-1:0] vcol_prev2 = '0;
    int                at_row = 0;
    int                at_col = 0;

    result_t   eroded_due [$];
    pix_item_t pix_backlog [$];

    // bookkeeping shared between processes
    int   items_queued   = 0;
    int   items_accepted = 0;
    int   results_seen   = 0;
    int   faults         = 0;
    int   settings_used  = 0;
    int   holds_asked    = 0;
    int   holds_served   = 0;
    logic pix_taken      = 1'b0;

    // stimulus side view of geometry and position
    int gen_w   = 10;
    int gen_r   = 480;
    int gen_row = 0;
    int gen_col = 0;

    // horizontal AND of a column word with its left and right neighbors
    function automatic logic [WORD_W-1:0] and_neighbours(
        input logic [WORD_W-1:0] left,
        input logic [WORD_W-1:0] mid,
        input logic [WORD_W-1:0] right
    );
        logic [WORD_W-1:0] west;
        logic [WORD_W-1:0] east;
        west = (mid << 1) | WORD_W'(left[WORD_W-1]);
        east = (mid >> 1) | {right[0], {(WORD_W-1){1'b0}}};
        return mid & west & east;
    endfunction

    function automatic void owe_word(
        input logic [WORD_W-1:0] word,
        input int                row,
        input int                col,
        input logic              last
    );
        result_t e;
        e.eroded_word = word;
        e.out_row     = ROW_W'(row);
        e.out_col     = COL_W'(col);
        e.frame_end   = last;
        eroded_due.push_back(e);
    endfunction

    function automatic void latch_register(
        input cfg_index_t            idx,
        input logic [CFG_DATA_W-1:0] data
    );
        case (idx)
            CFG_WORDS_PER_ROW: cfg_wpr  = data[WPR_W-1:0];
            CFG_ROW_TOTAL:     cfg_rows = data[ROW_W-1:0];
            CFG_BORDER_FILL:   cfg_fill = data[0];
            default: ;
        endcase
    endfunction

    // one accepted item: vertical AND, emit finished words of the row above
    function automatic void erode_item(input logic cmd, input logic [WORD_W-1:0] word);
        int                w;
        int                r;
        int                c;
        int                ri;
        logic              flush;
        logic [WORD_W-1:0] fillw;
        logic [WORD_W-1:0] bottom;
        logic [WORD_W-1:0] up;
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] left;
        w = int'(cfg_wpr);
        if (w < 1) w = 1;
        if (w > MAX_WORDS) w = MAX_WORDS;
        r = int'(cfg_rows);
        if (r < 1) r = 1;
        c = (at_col >= w) ? w - 1 : at_col;
        ri = at_row;
        flush = (ri >= r);
        if (flush) ri = r;
        fillw = {WORD_W{cfg_fill}};
        bottom = (cmd == CMD_FLUSH || flush) ? fillw : word;

        if (ri >= 1)
        begin
            up = (ri >= 2) ? two_up[c] : fillw;
            v = up & one_up[c] & bottom;
            if (c >= 1)
            begin
                left = (c == 1) ? fillw : vcol_prev2;
                owe_word(and_neighbours(left, vcol_prev, v), ri - 1, c - 1, 1'b0);
            end
            if (c == w - 1)
            begin
                left = (c == 0) ? fillw : vcol_prev;
                owe_word(and_neighbours(left, v, fillw), ri - 1, c, flush);
            end
            vcol_prev2 = vcol_prev;
            vcol_prev  = v;
        end

        two_up[c] = one_up[c];
        one_up[c] = bottom;

        if (c + 1 >= w)
        begin
            at_col = 0;
            at_row = flush ? 0 : ri + 1;
        end
        else
        begin
            at_col = c + 1;
            at_row = ri;
        end
    endfunction

    // pixel words biased toward dense content so erosion leaves something
    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] d;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        d = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return a;
            4:       return ~(WORD_W'(1) << $urandom_range(0, WORD_W - 1));
            default: return a | b | d;
        endcase
    endfunction

    // queue one item and follow the position it moves the block to
    task automatic push_item(input logic cmd, input logic [WORD_W-1:0] word);
        pix_item_t it;
        int        c;
        logic      flush;
        it.cmd  = cmd;
        it.word = word;
        pix_backlog.push_back(it);
        items_queued++;
        c = (gen_col >= gen_w) ? gen_w - 1 : gen_col;
        flush = (gen_row >= gen_r);
        if (flush) gen_row = gen_r;
        if (c + 1 >= gen_w)
        begin
            gen_col = 0;
            gen_row = flush ? 0 : gen_row + 1;
        end
        else
        begin
            gen_col = c + 1;
        end
    endtask

    // mostly well-formed rows, with stray flush ticks and stray image words
    task automatic push_items(input int n);
        logic cmd;
        repeat (n)
        begin
            if (gen_row >= gen_r)
                cmd = ($urandom_range(0, 9) == 0) ? CMD_IMAGE : CMD_FLUSH;
            else
                cmd = ($urandom_range(0, 19) == 0) ? CMD_FLUSH : CMD_IMAGE;
            push_item(cmd, pick_word());
        end
    endtask

    task automatic finish_frame();
        push_items(1);
        while (gen_row != 0 || gen_col != 0)
            push_items(1);
    endtask

    task automatic wait_idle();
        while (items_accepted != items_queued || eroded_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // write all three registers while nothing is in flight
    task automatic set_geometry(input int raw_w, input int raw_r, input int fill);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WORDS_PER_ROW;
        cfg_data  <= CFG_DATA_W'(raw_w);
        @(negedge clk);
        cfg_index <= CFG_ROW_TOTAL;
        cfg_data  <= CFG_DATA_W'(raw_r);
        @(negedge clk);
        cfg_index <= CFG_BORDER_FILL;
        cfg_data  <= CFG_DATA_W'(fill);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        gen_w = (raw_w < 1) ? 1 : (raw_w > MAX_WORDS) ? MAX_WORDS : raw_w;
        gen_r = (raw_r < 1) ? 1 : raw_r;
        settings_used++;
    endtask

    // sender: bursts of items from the backlog with random gaps
    int burst_left = 16;
    int gap_left   = 0;

    always @(negedge clk)
    begin : sender
        pix_item_t nxt;
        if (!rst_n)
        begin
            pix.valid      <= 1'b0;
            pix.cmd        <= CMD_IMAGE;
            pix.pixel_word <= '0;
        end
        else if (!pix.valid || pix_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                pix.valid <= 1'b0;
            end
            else if (pix_backlog.size() > 0)
            begin
                nxt = pix_backlog.pop_front();
                pix.valid      <= 1'b1;
                pix.cmd        <= nxt.cmd;
                pix.pixel_word <= nxt.word;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            else
            begin
                pix.valid <= 1'b0;
            end
        end
    end

    // receiver: changing stall styles, plus long holds on request
    ready_style_t ready_style = RDY_ALWAYS;
    int           style_span  = 0;
    int           stall_tick  = 0;
    int           hold_left   = 0;

    always @(negedge clk)
    begin : receiver
        if (!rst_n)
        begin
            res.ready <= 1'b0;
        end
        else if (holds_served < holds_asked)
        begin
            holds_served++;
            hold_left = LONG_HOLD;
            res.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            res.ready <= 1'b0;
        end
        else
        begin
            if (style_span == 0)
            begin
                ready_style = ready_style_t'($urandom_range(0, 3));
                style_span = $urandom_range(20, 80);
            end
            style_span--;
            stall_tick++;
            case (ready_style)
                RDY_ALWAYS: res.ready <= 1'b1;
                RDY_COIN:   res.ready <= 1'($urandom_range(0, 1));
                RDY_MOSTLY: res.ready <= (stall_tick % 4) != 3;
                default:    res.ready <= (stall_tick % 5) == 0;
            endcase
        end
    end

    // monitor: check results, track register writes, predict accepted items
    int stuck = 0;

    always @(posedge clk)
    begin : monitor
        logic    took_pix;
        logic    took_res;
        result_t got;
        result_t want;
        if (rst_n)
        begin
            took_pix = pix.valid && pix.ready;
            took_res = res.valid && res.ready;
            pix_taken = took_pix;

            if (took_res)
            begin
                got.eroded_word = res.eroded_word;
                got.out_row     = res.out_row;
                got.out_col     = res.out_col;
                got.frame_end   = res.frame_end;
                results_seen++;
                if (eroded_due.size() == 0)
                begin
                    faults++;
                    $display("%0t unexpected word: row %0d col %0d word %h frame_end %0b",
                             $time, got.out_row, got.out_col, got.eroded_word,
                             got.frame_end);
                end
                else
                begin
                    want = eroded_due.pop_front();
                    if (got !== want)
                    begin
                        faults++;
                        $display("%0t mismatch: expected row %0d col %0d word %h end %0b",
                                 $time, want.out_row, want.out_col, want.eroded_word,
                                 want.frame_end);
                        $display("%0t            actual row %0d col %0d word %h end %0b",
                                 $time, got.out_row, got.out_col, got.eroded_word,
                                 got.frame_end);
                    end
                end
            end

            if (cfg_we)
                latch_register(cfg_index, cfg_data);

            if (took_pix)
            begin
                erode_item(pix.cmd, pix.pixel_word);
                items_accepted++;
            end

            // watchdog on cycles with work pending and nothing moving
            if (took_pix || took_res ||
                (items_accepted == items_queued && eroded_due.size() == 0))
            begin
                stuck = 0;
            end
            else
            begin
                stuck++;
                if (stuck >= STUCK_LIMIT)
                begin
                    $display("%0t watchdog: nothing moved for %0d cycles, %0d words owed",
                             $time, stuck, eroded_due.size());
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    // stimulus and phase control
    initial
    begin : stimulus
        int w;
        int r;
        int fill;
        int pick;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_WORDS_PER_ROW;
        cfg_data       = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // two words, two rows, ones outside; a hole at the right edge of the row
        set_geometry(2, 2, 1);
        push_item(CMD_IMAGE, '1);
        push_item(CMD_IMAGE, 64'h7FFF_FFFF_FFFF_FFFF);
        push_item(CMD_IMAGE, '1);
        push_item(CMD_IMAGE, '1);
        push_item(CMD_FLUSH, '0);
        push_item(CMD_FLUSH, '1);

        // zero outside, flush tick inside the image, image word in flush row
        set_geometry(2, 3, 0);
        push_item(CMD_IMAGE, '1);
        push_item(CMD_IMAGE, '1);
        push_item(CMD_IMAGE, '1);
        push_item(CMD_IMAGE, 64'hFFFF_FFFF_FFFF_FFFE);
        push_item(CMD_IMAGE, '1);
        push_item(CMD_FLUSH, '0);
        push_item(CMD_IMAGE, 64'hAAAA_AAAA_AAAA_AAAA);
        push_item(CMD_FLUSH, '0);

        // zero width and zero rows act as one
        set_geometry(0, 0, 1);
        push_item(CMD_IMAGE, 64'h5555_5555_5555_5555);
        push_item(CMD_FLUSH, '0);
        set_geometry(1, 1, 0);
        push_item(CMD_IMAGE, '1);
        push_item(CMD_FLUSH, '0);

        // tallest frame cut short: row index lands beyond the new row count
        set_geometry(3, 4095, 0);
        push_items(12);
        set_geometry(3, 2, 1);
        finish_frame();

        // width shrinks mid-row: column lands beyond the new width
        set_geometry(4, 5, 0);
        push_items(14);
        set_geometry(2, 5, 1);
        finish_frame();

        // widest rows, with the receiver holding off for a long stretch
        set_geometry(64, 2, 1);
        push_items(3 * 64);
        holds_asked++;
        set_geometry(127, 1, 0);
        push_items(2 * 64);
        holds_asked++;

        // random geometries, mostly small
        while (items_queued < TARGET_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                w = $urandom_range(1, 6);
                r = $urandom_range(1, 5);
            end
            else if (pick < 9)
            begin
                w = $urandom_range(7, 64);
                r = $urandom_range(1, 2);
            end
            else
            begin
                w = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(65, 127);
                r = $urandom_range(0, 1);
            end
            fill = $urandom_range(0, 1);
            set_geometry(w, r, fill);
            if (gen_w >= 2 && gen_r >= 3 && $urandom_range(0, 3) == 0)
            begin
                push_items($urandom_range(gen_w, gen_r * gen_w - 1));
                if ($urandom_range(0, 1) == 1)
                    set_geometry($urandom_range(1, gen_w - 1), gen_r, $urandom_range(0, 1));
                else
                    set_geometry(gen_w, $urandom_range(1, gen_r), $urandom_range(0, 1));
                finish_frame();
            end
            else
            begin
                repeat ((gen_w > 6) ? 1 : $urandom_range(1, 3))
                    push_items((gen_r + 1) * gen_w);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (eroded_due.size() != 0)
        begin
            faults++;
            $display("%0t %0d eroded words never arrived", $time, eroded_due.size());
        end

        $display("%0d items over %0d register settings, %0d eroded words checked",
                 items_accepted, settings_used, results_seen);
        $display("widths 1 to 64 words, both fills, cut-short rows and columns, %0d holds",
                 holds_served);
        if (faults == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
sv/bero_pkg.sv
sv/bero_pix_if.sv
sv/bero_res_if.sv
sv/bero_ram.sv
sv/bero_core.sv
sv/bero_fifo.sv
sv/binary_erosion_3x3_packed_top.sv
sim/tb.sv
